/* hw/rtl/htfd_pkg.sv */
// Shared types, constants and arithmetic helpers for the sensor frame decoder.
package htfd_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Byte positions inside the six-byte frame
	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	localparam logic [14:0] T_SCALE    = 15'd17500;
	localparam logic [13:0] H_SCALE    = 14'd10000;
	localparam logic [14:0] T_OFFSET   = 15'd4500;
	localparam logic [15:0] FULL_SCALE = 16'hFFFF;

	localparam int DATA_W = 8;
	localparam int OUT_W  = 64;

	// Frame tracker to converter / top
	typedef struct packed {
		logic        last;   // this byte closes the frame
		logic        bad;    // checksum mismatch on either word
		logic [15:0] raw_t;
		logic [15:0] raw_h;
	} htfd_frame_t;

	typedef struct packed {
		logic               status;
		logic signed [14:0] temp_centi;
		logic [13:0]        hum_centi;
	} htfd_conv_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// floor(x / 65535) for x < 2^31: take x >> 16, remainder is lo + q0,
	// which stays below twice the divisor, so one correction step suffices.
	function automatic logic [15:0] div_full_scale(input logic [30:0] x);
		logic [14:0] q0;
		logic [16:0] rem;
		q0  = x[30:16];
		rem = {1'b0, x[15:0]} + {2'b00, q0};
		return {1'b0, q0} + {15'd0, (rem >= {1'b0, FULL_SCALE})};
	endfunction

endpackage

/* hw/rtl/humidity_temp_frame_decoder_top.sv */
// Top level of the humidity / temperature sensor frame decoder.
//
// Channel   Dir  Handshake                 Contents
// s_axis    in   tvalid/tready             tdata: data_byte; tuser: frame_start
// m_axis    out  tvalid/tready             tdata: four result fields; tuser: status
//
// Each request goes into an input register, is consumed by the CRC/position
// tracker unless the output register stalls, and on the sixth byte the
// converted result is loaded into the output register. One byte per cycle
// is sustained while no stall holds the input. The arithmetic path (one
// constant multiply plus a one-step divide by 65535) sets the clock limit.
// arst_n clears position, CRC, valid flags. A stalled result holds the
// pipeline only while the output register is occupied and not taken.
module humidity_temp_frame_decoder_top import htfd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic              s_axis_tuser,  // [0] frame_start
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [14:0] temperature_centi, [28:15] humidity_centi,
	// [44:29] raw_temperature, [60:45] raw_humidity, [63:61] zero
	output logic [OUT_W-1:0]  m_axis_tdata,
	output logic              m_axis_tuser   // [0] status
);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	// output register
	logic        out_valid_q;
	htfd_conv_t  conv_q;
	logic [15:0] raw_t_q;
	logic [15:0] raw_h_q;

	logic        stall;
	logic        step;
	htfd_frame_t frame;
	htfd_conv_t  conv;

	// Output register busy and not drained: freeze everything behind it
	assign stall         = out_valid_q && !m_axis_tready;
	assign step          = valid_s1 && !stall;
	assign s_axis_tready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	htfd_frame_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.frame       (frame)
	);

	htfd_convert u_convert (
		.frame (frame),
		.conv  (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= step && frame.last;
		end
	end

	always_ff @(posedge clk) begin
		if (step && frame.last) begin
			conv_q  <= conv;
			raw_t_q <= frame.raw_t;
			raw_h_q <= frame.raw_h;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = conv_q.status;
	assign m_axis_tdata  = {3'b000, raw_h_q, raw_t_q, conv_q.hum_centi, conv_q.temp_centi};

	// A result only appears after a request sat in the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1))
		else $error("result without a pending request");

	// Error results carry zero converted values
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[28:0] == 29'd0))
		else $error("converted fields nonzero on checksum error");

	// Good results stay within the sensor range
	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |->
		($signed(m_axis_tdata[14:0]) >= -15'sd4500 &&
		 $signed(m_axis_tdata[14:0]) <= 15'sd13000 &&
		 m_axis_tdata[28:15] <= 14'd10000))
		else $error("converted value out of range");

	// Input side only backs up when both registers are occupied
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without cause");

endmodule

/* hw/rtl/htfd_frame_track.sv */
// Frame position, running CRC and raw word capture.
module htfd_frame_track import htfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,        // consume one byte
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	output htfd_frame_t frame
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] hum_word_q;
	logic        first_good_q;

	logic [2:0]  pos_eff;
	logic [7:0]  crc_seed;
	logic [7:0]  crc_next;

	assign pos_eff  = (frame_start || pos_q > POS_H_CRC) ? POS_T_HI : pos_q;
	assign crc_seed = (pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? CRC_INIT : crc_q;
	assign crc_next = crc8_byte(crc_seed, data_byte);

	always_comb begin
		frame.last  = (pos_eff == POS_H_CRC);
		frame.bad   = !(first_good_q && data_byte == crc_q);
		frame.raw_t = temp_word_q;
		frame.raw_h = hum_word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_T_HI;
			crc_q        <= CRC_INIT;
			temp_word_q  <= '0;
			hum_word_q   <= '0;
			first_good_q <= 1'b0;
		end else if (step) begin
			unique case (pos_eff)
				POS_T_HI: begin
					crc_q       <= crc_next;
					temp_word_q <= {data_byte, 8'h00};
				end
				POS_T_LO: begin
					crc_q       <= crc_next;
					temp_word_q <= {temp_word_q[15:8], data_byte};
				end
				POS_T_CRC: begin
					first_good_q <= (data_byte == crc_q);
					crc_q        <= CRC_INIT;
				end
				POS_H_HI: begin
					crc_q      <= crc_next;
					hum_word_q <= {data_byte, 8'h00};
				end
				POS_H_LO: begin
					crc_q      <= crc_next;
					hum_word_q <= {hum_word_q[15:8], data_byte};
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
			pos_q <= frame.last ? POS_T_HI : pos_eff + 3'd1;
		end
	end

endmodule

/* hw/rtl/htfd_convert.sv */
// Raw word to engineering unit conversion.
module htfd_convert import htfd_pkg::*; (
	input  htfd_frame_t frame,
	output htfd_conv_t  conv
);

	logic [30:0] t_prod;
	logic [30:0] h_prod;
	logic [15:0] t_quot;
	logic [15:0] h_quot;

	assign t_prod = {15'd0, frame.raw_t} * {16'd0, T_SCALE};
	assign h_prod = {15'd0, frame.raw_h} * {17'd0, H_SCALE};
	assign t_quot = div_full_scale(t_prod);
	assign h_quot = div_full_scale(h_prod);

	always_comb begin
		conv.status = frame.bad;
		if (frame.bad) begin
			conv.temp_centi = '0;
			conv.hum_centi  = '0;
		end else begin
			conv.temp_centi = $signed(t_quot[14:0] - T_OFFSET);
			conv.hum_centi  = h_quot[13:0];
		end
	end

endmodule
